// File: design/two_axis_servo_slew_limiter_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the two-axis servo slew limiter
// Clocked implication checks with asynchronous reset disable.
// -----------------------------------------------------------------------------
`ifndef TWO_AXIS_SERVO_SLEW_LIMITER_MACROS_SVH
`define TWO_AXIS_SERVO_SLEW_LIMITER_MACROS_SVH

// same-cycle implication
`define TSSL_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tssl assertion failed");

// next-cycle implication
`define TSSL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tssl assertion failed");

`endif

// File: design/tssl_pkg.sv
// -----------------------------------------------------------------------------
// tssl_pkg
// Types, codes and the shared range-check helper of the two-axis servo slew limiter.
// -----------------------------------------------------------------------------
package tssl_pkg;

	localparam int PWM_BITS   = 12;
	localparam int ANGLE_FRAC = 16;
	localparam int ANGLE_BITS = 20;
	localparam int PROD_W     = 45;
	localparam int CFG_DATA_W = 24;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic signed [ANGLE_BITS+1:0] angle_wide_t;

	typedef enum logic [1:0] {
		FUNC_SET  = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_JUMP = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_PAN_RANGE  = 2'd1,
		ST_TILT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_SET,
		OP_TICK,
		OP_JUMP,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_ANGLE   = 3'd0,
		REG_MAX_ANGLE   = 3'd1,
		REG_STEP        = 3'd2,
		REG_DEADZONE    = 3'd3,
		REG_PAN_SLOPE   = 3'd4,
		REG_PAN_OFFSET  = 3'd5,
		REG_TILT_SLOPE  = 3'd6,
		REG_TILT_OFFSET = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  func;
		angle_t      pan_angle;
		angle_t      tilt_angle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [PWM_BITS-1:0] pan_ticks;
		logic [PWM_BITS-1:0] tilt_ticks;
		logic                pwm_write;
		logic                on_target;
	} res_t;

	typedef struct packed {
		angle_t              min_angle;
		angle_t              max_angle;
		logic [15:0]         step_per_tick;
		logic [15:0]         deadzone;
		logic [23:0]         pan_slope;
		logic [PWM_BITS-1:0] pan_offset;
		logic [23:0]         tilt_slope;
		logic [PWM_BITS-1:0] tilt_offset;
	} cfg_t;

	typedef struct packed {
		op_t     op;
		status_t status;
		angle_t  pan_angle;
		angle_t  tilt_angle;
	} entry_t;

	function automatic logic in_limits(angle_wide_t a, angle_t lo, angle_t hi);
		return (a >= lo) && (a <= hi);
	endfunction

endpackage

// File: design/tssl_front.sv
// -----------------------------------------------------------------------------
// tssl_front
// Decodes incoming command words and range-checks their angles.
// -----------------------------------------------------------------------------
module tssl_front (
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  tssl_pkg::cmd_t   cmd,
	input  tssl_pkg::cfg_t   cfg,
	output logic             push_valid,
	input  logic             push_ready,
	output tssl_pkg::entry_t push
);
	import tssl_pkg::*;

	logic    pan_ok;
	logic    tilt_ok;
	status_t range_status;

	assign pan_ok  = in_limits(angle_wide_t'(cmd.pan_angle), cfg.min_angle, cfg.max_angle);
	assign tilt_ok = in_limits(angle_wide_t'(cmd.tilt_angle), cfg.min_angle, cfg.max_angle);

	always_comb begin
		priority if (!pan_ok) begin
			range_status = ST_PAN_RANGE;
		end else if (!tilt_ok) begin
			range_status = ST_TILT_RANGE;
		end else begin
			range_status = ST_OK;
		end
	end

	always_comb begin
		push.pan_angle  = cmd.pan_angle;
		push.tilt_angle = cmd.tilt_angle;
		unique case (func_t'(cmd.func))
			FUNC_SET: begin
				push.op     = OP_SET;
				push.status = range_status;
			end
			FUNC_TICK: begin
				push.op     = OP_TICK;
				push.status = ST_OK;
			end
			FUNC_JUMP: begin
				push.op     = OP_JUMP;
				push.status = range_status;
			end
			default: begin
				push.op     = OP_NOP;
				push.status = ST_OK;
			end
		endcase
	end

	assign push_valid = cmd_valid;
	assign cmd_ready  = push_ready;

endmodule

// File: design/tssl_queue.sv
// -----------------------------------------------------------------------------
// tssl_queue
// Two-entry queue of decoded words between front and back.
// -----------------------------------------------------------------------------
module tssl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tssl_pkg::entry_t push,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tssl_pkg::entry_t pop
);
	import tssl_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop        = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push;
		end
	end

endmodule

// File: design/tssl_back.sv
// -----------------------------------------------------------------------------
// tssl_back
// Holds the servo state, executes decoded words and maps angles to PWM ticks.
// -----------------------------------------------------------------------------
module tssl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tssl_pkg::cfg_t   cfg,
	input  logic             head_valid,
	output logic             head_ready,
	input  tssl_pkg::entry_t head,
	output logic             res_valid,
	input  logic             res_ready,
	output tssl_pkg::res_t   res
);
	import tssl_pkg::*;

	function automatic logic in_window(angle_t pos, angle_t tgt, logic [15:0] dz);
		angle_wide_t d;
		angle_wide_t w;
		d = angle_wide_t'(pos) - angle_wide_t'(tgt);
		w = angle_wide_t'({1'b0, dz});
		return (d >= -w) && (d <= w);
	endfunction

	function automatic logic [PWM_BITS-1:0] to_ticks(logic signed [PROD_W-1:0] prod,
			logic [PWM_BITS-1:0] offset);
		logic signed [PROD_W-1:0] q;
		logic signed [PROD_W:0]   sum;
		logic signed [PROD_W:0]   top;
		q   = prod >>> ANGLE_FRAC;
		top = $signed({{(PROD_W+1-PWM_BITS){1'b0}}, {PWM_BITS{1'b1}}});
		sum = (PROD_W+1)'(q) + $signed({{(PROD_W+1-PWM_BITS){1'b0}}, offset});
		if (sum < 0) begin
			return '0;
		end else if (sum > top) begin
			return '1;
		end
		return sum[PWM_BITS-1:0];
	endfunction

	// servo state
	angle_t pan_pos_q, tilt_pos_q, pan_tgt_q, tilt_tgt_q;
	logic   pan_up_q, tilt_up_q, easing_q;

	angle_t  pan_pos_n, tilt_pos_n, pan_tgt_n, tilt_tgt_n;
	logic    pan_up_n, tilt_up_n, easing_n;
	status_t st_n;
	logic    write_n;
	logic    use_pre_n;

	logic        pan_win, tilt_win, at_pre;
	angle_wide_t step_w;
	angle_wide_t pan_plus, pan_minus, tilt_plus, tilt_minus;
	angle_wide_t pan_next, tilt_next;
	logic        pan_next_ok, tilt_next_ok;
	status_t     tick_status;

	// stage 1: post-execute state
	logic    valid_s1;
	status_t status_s1;
	logic    write_s1, use_pre_s1, at_pre_s1;
	angle_t  pan_pos_s1, tilt_pos_s1, pan_tgt_s1, tilt_tgt_s1;

	// stage 2: products
	logic                     valid_s2;
	status_t                  status_s2;
	logic                     write_s2, at_s2;
	logic signed [PROD_W-1:0] pan_prod_s2, tilt_prod_s2;

	// stage 3: result register
	logic valid_s3;
	res_t res_s3;

	logic rdy_s1, rdy_s2, rdy_s3;
	logic fire;

	assign rdy_s3     = !valid_s3 || res_ready;
	assign rdy_s2     = !valid_s2 || rdy_s3;
	assign rdy_s1     = !valid_s1 || rdy_s2;
	assign head_ready = rdy_s1;
	assign fire       = head_valid && rdy_s1;

	assign pan_win  = in_window(pan_pos_q, pan_tgt_q, cfg.deadzone);
	assign tilt_win = in_window(tilt_pos_q, tilt_tgt_q, cfg.deadzone);
	assign at_pre   = pan_win && tilt_win;

	assign step_w     = angle_wide_t'({1'b0, cfg.step_per_tick});
	assign pan_plus   = angle_wide_t'(pan_pos_q) + step_w;
	assign pan_minus  = angle_wide_t'(pan_pos_q) - step_w;
	assign tilt_plus  = angle_wide_t'(tilt_pos_q) + step_w;
	assign tilt_minus = angle_wide_t'(tilt_pos_q) - step_w;

	assign pan_next  = pan_win ? angle_wide_t'(pan_pos_q) : (pan_up_q ? pan_plus : pan_minus);
	assign tilt_next = tilt_win ? angle_wide_t'(tilt_pos_q) :
		(tilt_up_q ? tilt_plus : tilt_minus);

	assign pan_next_ok  = in_limits(pan_next, cfg.min_angle, cfg.max_angle);
	assign tilt_next_ok = in_limits(tilt_next, cfg.min_angle, cfg.max_angle);

	always_comb begin
		priority if (!pan_next_ok) begin
			tick_status = ST_PAN_RANGE;
		end else if (!tilt_next_ok) begin
			tick_status = ST_TILT_RANGE;
		end else begin
			tick_status = ST_OK;
		end
	end

	always_comb begin
		pan_pos_n  = pan_pos_q;
		tilt_pos_n = tilt_pos_q;
		pan_tgt_n  = pan_tgt_q;
		tilt_tgt_n = tilt_tgt_q;
		pan_up_n   = pan_up_q;
		tilt_up_n  = tilt_up_q;
		easing_n   = easing_q;
		st_n       = ST_OK;
		write_n    = 1'b0;
		use_pre_n  = 1'b0;
		unique case (head.op)
			OP_SET: begin
				st_n = head.status;
				if (head.status == ST_OK) begin
					pan_up_n   = head.pan_angle > pan_pos_q;
					tilt_up_n  = head.tilt_angle > tilt_pos_q;
					pan_tgt_n  = head.pan_angle;
					tilt_tgt_n = head.tilt_angle;
					easing_n   = 1'b1;
				end
			end
			OP_TICK: begin
				if (easing_q) begin
					use_pre_n = 1'b1;
					st_n      = tick_status;
					if (tick_status == ST_OK) begin
						pan_pos_n  = pan_next[ANGLE_BITS-1:0];
						tilt_pos_n = tilt_next[ANGLE_BITS-1:0];
						write_n    = 1'b1;
						if (at_pre) begin
							easing_n = 1'b0;
						end
					end else begin
						easing_n = 1'b0;
					end
				end
			end
			OP_JUMP: begin
				st_n = head.status;
				if (head.status == ST_OK) begin
					pan_pos_n  = head.pan_angle;
					tilt_pos_n = head.tilt_angle;
					write_n    = 1'b1;
					easing_n   = 1'b0;
				end
			end
			default: begin
				st_n = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_pos_q  <= '0;
			tilt_pos_q <= '0;
			pan_tgt_q  <= '0;
			tilt_tgt_q <= '0;
			pan_up_q   <= 1'b0;
			tilt_up_q  <= 1'b0;
			easing_q   <= 1'b0;
		end else if (fire) begin
			pan_pos_q  <= pan_pos_n;
			tilt_pos_q <= tilt_pos_n;
			pan_tgt_q  <= pan_tgt_n;
			tilt_tgt_q <= tilt_tgt_n;
			pan_up_q   <= pan_up_n;
			tilt_up_q  <= tilt_up_n;
			easing_q   <= easing_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= head_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1   <= st_n;
			write_s1    <= write_n;
			use_pre_s1  <= use_pre_n;
			at_pre_s1   <= at_pre;
			pan_pos_s1  <= pan_pos_n;
			tilt_pos_s1 <= tilt_pos_n;
			pan_tgt_s1  <= pan_tgt_n;
			tilt_tgt_s1 <= tilt_tgt_n;
		end
		if (rdy_s2 && valid_s1) begin
			status_s2    <= status_s1;
			write_s2     <= write_s1;
			at_s2        <= use_pre_s1 ? at_pre_s1 :
				(in_window(pan_pos_s1, pan_tgt_s1, cfg.deadzone) &&
				 in_window(tilt_pos_s1, tilt_tgt_s1, cfg.deadzone));
			pan_prod_s2  <= $signed({1'b0, cfg.pan_slope}) * pan_pos_s1;
			tilt_prod_s2 <= $signed({1'b0, cfg.tilt_slope}) * tilt_pos_s1;
		end
		if (rdy_s3 && valid_s2) begin
			res_s3.status     <= status_s2;
			res_s3.pan_ticks  <= to_ticks(pan_prod_s2, cfg.pan_offset);
			res_s3.tilt_ticks <= to_ticks(tilt_prod_s2, cfg.tilt_offset);
			res_s3.pwm_write  <= write_s2;
			res_s3.on_target  <= at_s2;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

// File: design/two_axis_servo_slew_limiter.sv
// -----------------------------------------------------------------------------
// two_axis_servo_slew_limiter: pan/tilt servo position generator
// Path: queue slot, then execute, product and result registers to result valid.
// Throughput: one word per cycle unless res_ready stalls the result side.
// Reset: asynchronous, clears state and queue, loads register defaults.
// -----------------------------------------------------------------------------
`include "two_axis_servo_slew_limiter_macros.svh"

module two_axis_servo_slew_limiter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  tssl_pkg::cmd_t                cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output tssl_pkg::res_t                res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  tssl_pkg::cfg_reg_t            cfg_index,
	input  logic [tssl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tssl_pkg::*;

	cfg_t   cfg_q;
	logic   push_valid, push_ready;
	entry_t push;
	logic   head_valid, head_ready;
	entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_angle     <= angle_t'(0);
			cfg_q.max_angle     <= angle_t'(205887);
			cfg_q.step_per_tick <= 16'd341;
			cfg_q.deadzone      <= 16'd1966;
			cfg_q.pan_slope     <= '0;
			cfg_q.pan_offset    <= '0;
			cfg_q.tilt_slope    <= '0;
			cfg_q.tilt_offset   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_ANGLE:   cfg_q.min_angle     <= cfg_data[ANGLE_BITS-1:0];
				REG_MAX_ANGLE:   cfg_q.max_angle     <= cfg_data[ANGLE_BITS-1:0];
				REG_STEP:        cfg_q.step_per_tick <= cfg_data[15:0];
				REG_DEADZONE:    cfg_q.deadzone      <= cfg_data[15:0];
				REG_PAN_SLOPE:   cfg_q.pan_slope     <= cfg_data[23:0];
				REG_PAN_OFFSET:  cfg_q.pan_offset    <= cfg_data[PWM_BITS-1:0];
				REG_TILT_SLOPE:  cfg_q.tilt_slope    <= cfg_data[23:0];
				REG_TILT_OFFSET: cfg_q.tilt_offset   <= cfg_data[PWM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	tssl_front u_front (
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push)
	);

	tssl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop        (head)
	);

	tssl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	`TSSL_ASSERT_SAME(a_write_only_ok, clk, arst_n, res_valid && res.pwm_write, res.status == ST_OK)
	`TSSL_ASSERT_SAME(a_full_has_head, clk, arst_n, !cmd_ready, head_valid)
	`TSSL_ASSERT_NEXT(a_push_fills, clk, arst_n, push_valid && push_ready, head_valid)

endmodule

// File: verif/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top: testbench of the two-axis servo slew limiter
// Sends set-target, control-tick, jump and unused commands under several
// register settings, the window and step extremes among them, with random
// gaps on the command side and random stalls on the result side. A predictor
// tracks positions, targets, directions and easing, and every result word is
// checked field by field, in order, against the predicted word.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tssl_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	cmd_t               cmd = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	res_t               res;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	cfg_reg_t           cfg_index = REG_MIN_ANGLE;
	logic [23:0]        cfg_data = '0;

	two_axis_servo_slew_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t   cfg_shadow = '{min_angle: 20'sd0, max_angle: 20'sd205887,
		step_per_tick: 16'd341, deadzone: 16'd1966, pan_slope: 24'd0,
		pan_offset: 12'd0, tilt_slope: 24'd0, tilt_offset: 12'd0};
	angle_t pan_pos = '0;
	angle_t tilt_pos = '0;
	angle_t pan_tgt = '0;
	angle_t tilt_tgt = '0;
	bit     pan_up = 1'b0;
	bit     tilt_up = 1'b0;
	bit     easing = 1'b0;

	cmd_t   queued_cmds[$];
	res_t   predicted_res[$];

	int     n_fail = 0;
	int     n_words = 0;
	int     n_func[4] = '{0, 0, 0, 0};
	int     n_reject = 0;
	int     n_moves = 0;
	int     n_arrive = 0;
	int     n_settings = 0;
	int     send_wait = 0;
	int     recv_wait = 0;
	bit     send_steady = 1'b0;
	int     quiet = 0;

	function automatic longint as_long(angle_t a);
		return a;
	endfunction

	function automatic bit near_target(longint pos, longint tgt);
		longint dz;
		dz = cfg_shadow.deadzone;
		return pos >= tgt - dz && pos <= tgt + dz;
	endfunction

	function automatic status_t range_code(longint pan, longint tilt);
		longint lo, hi;
		lo = as_long(cfg_shadow.min_angle);
		hi = as_long(cfg_shadow.max_angle);
		if (pan < lo || pan > hi)
			return ST_PAN_RANGE;
		if (tilt < lo || tilt > hi)
			return ST_TILT_RANGE;
		return ST_OK;
	endfunction

	function automatic logic [PWM_BITS-1:0] ticks_of(logic [23:0] slope,
			logic [PWM_BITS-1:0] offset, angle_t a);
		longint prod, q;
		prod = longint'(slope) * as_long(a);
		q = (prod >>> ANGLE_FRAC) + longint'(offset);
		if (q < 0)
			q = 0;
		if (q > (longint'(1) << PWM_BITS) - 1)
			q = (longint'(1) << PWM_BITS) - 1;
		return q[PWM_BITS-1:0];
	endfunction

	function automatic res_t servo_predict(cmd_t c);
		res_t    r;
		status_t code;
		longint  pa, ta, np, nt, st;
		bit      wr, at, ticked, pan_in, tilt_in;
		pa = as_long(c.pan_angle);
		ta = as_long(c.tilt_angle);
		code = ST_OK;
		wr = 1'b0;
		at = 1'b0;
		ticked = 1'b0;
		n_func[c.func]++;
		case (c.func)
			FUNC_SET: begin
				code = range_code(pa, ta);
				if (code == ST_OK) begin
					pan_up = pa > as_long(pan_pos);
					tilt_up = ta > as_long(tilt_pos);
					pan_tgt = c.pan_angle;
					tilt_tgt = c.tilt_angle;
					easing = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (easing) begin
					pan_in = near_target(as_long(pan_pos), as_long(pan_tgt));
					tilt_in = near_target(as_long(tilt_pos), as_long(tilt_tgt));
					st = cfg_shadow.step_per_tick;
					np = as_long(pan_pos);
					nt = as_long(tilt_pos);
					if (!pan_in)
						np += pan_up ? st : -st;
					if (!tilt_in)
						nt += tilt_up ? st : -st;
					at = pan_in && tilt_in;
					ticked = 1'b1;
					code = range_code(np, nt);
					if (at)
						n_arrive++;
					if (code == ST_OK) begin
						pan_pos = angle_t'(np);
						tilt_pos = angle_t'(nt);
						wr = 1'b1;
						n_moves++;
						if (at)
							easing = 1'b0;
					end else begin
						easing = 1'b0;
					end
				end
			end
			FUNC_JUMP: begin
				code = range_code(pa, ta);
				if (code == ST_OK) begin
					pan_pos = c.pan_angle;
					tilt_pos = c.tilt_angle;
					wr = 1'b1;
					easing = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (code != ST_OK)
			n_reject++;
		if (!ticked)
			at = near_target(as_long(pan_pos), as_long(pan_tgt)) &&
				near_target(as_long(tilt_pos), as_long(tilt_tgt));
		r.status = code;
		r.pan_ticks = ticks_of(cfg_shadow.pan_slope, cfg_shadow.pan_offset, pan_pos);
		r.tilt_ticks = ticks_of(cfg_shadow.tilt_slope, cfg_shadow.tilt_offset, tilt_pos);
		r.pwm_write = wr;
		r.on_target = at;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		n_fail++;
		if (n_fail <= 40)
			$display("%0t ns word %0d: %s got %0d want %0d", $time, n_words, what,
				got, want);
	endtask

	task automatic check_word(res_t got);
		res_t want;
		if (predicted_res.size() == 0) begin
			report_mismatch("unexpected word, status", got.status, 0);
		end else begin
			want = predicted_res.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.pan_ticks !== want.pan_ticks)
				report_mismatch("pan_ticks", got.pan_ticks, want.pan_ticks);
			if (got.tilt_ticks !== want.tilt_ticks)
				report_mismatch("tilt_ticks", got.tilt_ticks, want.tilt_ticks);
			if (got.pwm_write !== want.pwm_write)
				report_mismatch("pwm_write", got.pwm_write, want.pwm_write);
			if (got.on_target !== want.on_target)
				report_mismatch("on_target", got.on_target, want.on_target);
		end
		n_words++;
	endtask

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_wait <= 0;
			send_steady <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				predicted_res.push_back(servo_predict(cmd));
			if ($urandom_range(0, 63) == 0)
				send_steady <= !send_steady;
			if (!cmd_valid || cmd_ready) begin
				if (send_wait > 0) begin
					cmd_valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (queued_cmds.size() != 0) begin
					cmd <= queued_cmds.pop_front();
					cmd_valid <= 1'b1;
					send_wait <= send_steady ? 0 : pick_pause();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			res_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			w = recv_wait;
			if (res_valid && res_ready) begin
				check_word(res);
				w = ($urandom_range(0, 3) == 0) ? 0 : pick_pause();
			end else if (w > 0) begin
				w = w - 1;
			end
			recv_wait <= w;
			res_ready <= (w == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) ||
					(cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic push_cmd(func_t f, longint pan, longint tilt);
		cmd_t c;
		c.func = f;
		c.pan_angle = angle_t'(pan);
		c.tilt_angle = angle_t'(tilt);
		queued_cmds.push_back(c);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MIN_ANGLE:   cfg_shadow.min_angle = val[ANGLE_BITS-1:0];
			REG_MAX_ANGLE:   cfg_shadow.max_angle = val[ANGLE_BITS-1:0];
			REG_STEP:        cfg_shadow.step_per_tick = val[15:0];
			REG_DEADZONE:    cfg_shadow.deadzone = val[15:0];
			REG_PAN_SLOPE:   cfg_shadow.pan_slope = val;
			REG_PAN_OFFSET:  cfg_shadow.pan_offset = val[PWM_BITS-1:0];
			REG_TILT_SLOPE:  cfg_shadow.tilt_slope = val;
			REG_TILT_OFFSET: cfg_shadow.tilt_offset = val[PWM_BITS-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_cfg(cfg_t c);
		cfg_write(REG_MIN_ANGLE, {4'($urandom), c.min_angle});
		cfg_write(REG_MAX_ANGLE, {4'($urandom), c.max_angle});
		cfg_write(REG_STEP, {8'($urandom), c.step_per_tick});
		cfg_write(REG_DEADZONE, {8'($urandom), c.deadzone});
		cfg_write(REG_PAN_SLOPE, c.pan_slope);
		cfg_write(REG_PAN_OFFSET, {12'($urandom), c.pan_offset});
		cfg_write(REG_TILT_SLOPE, c.tilt_slope);
		cfg_write(REG_TILT_OFFSET, {12'($urandom), c.tilt_offset});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic cfg_t make_cfg(longint mn, longint mx, longint st, longint dz,
			longint ps, longint po, longint ts, longint tof);
		cfg_t c;
		c.min_angle = angle_t'(mn);
		c.max_angle = angle_t'(mx);
		c.step_per_tick = 16'(st);
		c.deadzone = 16'(dz);
		c.pan_slope = 24'(ps);
		c.pan_offset = 12'(po);
		c.tilt_slope = 24'(ts);
		c.tilt_offset = 12'(tof);
		return c;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t   c;
		angle_t a, b, x;
		a = angle_t'($urandom);
		b = angle_t'($urandom);
		if (a > b) begin
			x = a;
			a = b;
			b = x;
		end
		c.min_angle = a;
		c.max_angle = b;
		c.step_per_tick = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 6000));
		c.deadzone = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 4000));
		c.pan_slope = 24'($urandom);
		c.pan_offset = 12'($urandom);
		c.tilt_slope = 24'($urandom);
		c.tilt_offset = 12'($urandom);
		return c;
	endfunction

	function automatic longint pick_in(longint lo, longint hi);
		if (lo > hi)
			return as_long(angle_t'($urandom));
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			default: return lo + longint'($urandom_range(0, int'(hi - lo)));
		endcase
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		if (lo > hi)
			return v;
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// mostly jump / set / tick runs with random content, the rest loose noise
	task automatic gen_phase(int n);
		longint lo, hi, st, span, p0, t0, pt, tt, reach;
		int     made, ticks, k;
		lo = as_long(cfg_shadow.min_angle);
		hi = as_long(cfg_shadow.max_angle);
		st = cfg_shadow.step_per_tick;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) < 7) begin
				p0 = pick_in(lo, hi);
				t0 = pick_in(lo, hi);
				if ($urandom_range(0, 7) != 0) begin
					push_cmd(FUNC_JUMP, p0, t0);
					made++;
				end
				span = 4 * st + 2 * longint'(cfg_shadow.deadzone) + 16;
				if ($urandom_range(0, 3) == 0) begin
					pt = pick_in(lo, hi);
					tt = pick_in(lo, hi);
				end else begin
					pt = clamp_to(p0 + longint'($urandom_range(0, int'(2 * span))) - span,
						lo, hi);
					tt = clamp_to(t0 + longint'($urandom_range(0, int'(2 * span))) - span,
						lo, hi);
				end
				push_cmd(FUNC_SET, pt, tt);
				made++;
				reach = (pt > p0) ? pt - p0 : p0 - pt;
				if (tt - t0 > reach)
					reach = tt - t0;
				if (t0 - tt > reach)
					reach = t0 - tt;
				if (st == 0)
					ticks = $urandom_range(1, 4);
				else
					ticks = int'((reach / st > 40) ? 40 : reach / st) + $urandom_range(1, 3);
				repeat (ticks)
					push_cmd(FUNC_TICK, as_long(angle_t'($urandom)),
						as_long(angle_t'($urandom)));
				made += ticks;
			end else begin
				k = $urandom_range(1, 4);
				repeat (k) begin
					push_cmd(func_t'($urandom_range(0, 3)), as_long(angle_t'($urandom)),
						as_long(angle_t'($urandom)));
					made++;
				end
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (queued_cmds.size() != 0 || cmd_valid || predicted_res.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		cfg_t plan[$];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: idle tick, unused code, rejections, short ease
		@(negedge clk);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_NONE, 524287, -524288);
		push_cmd(FUNC_SET, -1, 0);
		push_cmd(FUNC_SET, 100, 205888);
		push_cmd(FUNC_JUMP, 205888, 0);
		push_cmd(FUNC_SET, 2000, 0);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_TICK, 0, 0);
		wait_idle();

		// full window, largest step, no deadzone, saturating slopes
		apply_cfg(make_cfg(-524288, 524287, 65535, 0, 16777215, 4095, 65536, 0));
		@(negedge clk);
		push_cmd(FUNC_JUMP, 524287, -524288);
		push_cmd(FUNC_SET, -524288, 524287);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_JUMP, 524287, 524287);
		push_cmd(FUNC_SET, 524287, 524287);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_JUMP, -1, -1);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_JUMP, 524000, 0);
		push_cmd(FUNC_SET, 524287, 0);
		push_cmd(FUNC_TICK, 0, 0);
		push_cmd(FUNC_JUMP, 0, -524000);
		push_cmd(FUNC_SET, 0, -524288);
		push_cmd(FUNC_TICK, 0, 0);
		wait_idle();

		plan.push_back(make_cfg(-524288, 524287, 3000, 500, 100 << 16, 2048,
			(37 << 16) + 12345, 1024));
		plan.push_back(make_cfg(-100000, 100000, 0, 0, 16777215, 0, 16777215, 0));
		plan.push_back(make_cfg(-524288, 524287, 65535, 65535, 0, 4095, 0, 4095));
		plan.push_back(make_cfg(5000, -5000, 1200, 300, 200 << 16, 100, 50 << 16, 3000));
		plan.push_back(make_cfg(0, 205887, 341, 1966, 150 << 16, 1500, 90 << 16, 2500));
		repeat (4)
			plan.push_back(random_cfg());
		foreach (plan[i]) begin
			apply_cfg(plan[i]);
			@(negedge clk);
			gen_phase((i == 3) ? 60 : ((i < 3 || i == 4) ? 130 : 135));
			wait_idle();
		end

		if (predicted_res.size() != 0)
			report_mismatch("words never returned", predicted_res.size(), 0);
		$display("ran %0d set, %0d tick, %0d jump, %0d unused commands over %0d settings",
			n_func[FUNC_SET], n_func[FUNC_TICK], n_func[FUNC_JUMP], n_func[FUNC_NONE],
			n_settings);
		$display("%0d range rejections, %0d stepping ticks, %0d ticks found on target",
			n_reject, n_moves, n_arrive);
		if (n_fail == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/tssl_pkg.sv
design/tssl_front.sv
design/tssl_queue.sv
design/tssl_back.sv
design/two_axis_servo_slew_limiter.sv
verif/tb_top.sv
